[sv/srle_pkg.sv]
// ----------------------------------------------------------------------------
// srle_pkg: shared types and constants of the sprite row run-length encoder
// Run kinds, byte codes, write-bundle layout constants and queue status.
// ----------------------------------------------------------------------------
`default_nettype none

package srle_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_RUN     = 127;
    localparam int DEF_ADDR_BITS   = 24;
    localparam int DEF_QUEUE_DEPTH = 4;

    // A run length is always held in seven bits.
    localparam int RUN_LEN_W = 7;

    // One pixel causes at most four byte writes.
    localparam int MAX_WRITES = 4;
    localparam int WIDX_W     = 2;
    localparam int CNT_W      = 3;
    localparam int BYTE_W     = 8;

    localparam logic [BYTE_W-1:0] ROW_MARK = 8'h80;

    typedef enum logic [1:0] {
        RUN_NONE   = 2'd0,
        RUN_TRANS  = 2'd1,
        RUN_OPAQUE = 2'd2
    } t_run_kind;

    // Status of the queue between the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

[sv/sprite_row_rle_encoder_top.sv]
// ----------------------------------------------------------------------------
// sprite_row_rle_encoder_top: row-wise transparent run-length encoder
// Encodes 8-bit palette pixels into runs and emits addressed byte writes.
//
// Input channel (i_valid / o_ready): one pixel word per cycle with its
// row-end and image-start marks. A pixel is taken in the cycle it arrives
// as long as the bundle queue has room.
// Output channel (o_valid / i_ready): one byte write word per cycle, an 8-bit
// value and its stream address; o_last_of_item marks the final write caused
// by a pixel. Pixels that cause no write produce nothing.
// Writes pass the bundle queue, the bundle register and the output register.
// Throughput: one pixel per cycle on the input and one write per cycle on
// the output; a pixel causes up to four writes, so bursts at run and row ends
// are absorbed by the QUEUE_DEPTH-entry bundle queue and input stalls only
// when that queue is full.
// When the receiver stalls, the output word holds and the queue fills; the
// input keeps flowing until the queue is full.
// Reset clears the open run, the write address and both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_row_rle_encoder_top #(
    parameter int MAX_RUN     = srle_pkg::DEF_MAX_RUN,
    parameter int ADDR_BITS   = srle_pkg::DEF_ADDR_BITS,
    parameter int QUEUE_DEPTH = srle_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [7:0]           i_pixel,
    input  wire logic                 i_row_end,
    input  wire logic                 i_image_start,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [7:0]                o_out_byte,
    output logic [ADDR_BITS-1:0]      o_out_addr,
    output logic                      o_last_of_item
);
    import srle_pkg::*;

    localparam int BUN_W = MAX_WRITES * (BYTE_W + ADDR_BITS) + WIDX_W;

    t_qstat           qstat;
    logic             push;
    logic             pop;
    logic [BUN_W-1:0] bun_in;
    logic [BUN_W-1:0] bun_out;

    srle_front #(
        .MAX_RUN   (MAX_RUN),
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel       (i_pixel),
        .i_row_end     (i_row_end),
        .i_image_start (i_image_start),
        .i_qstat       (qstat),
        .o_push        (push),
        .o_bundle      (bun_in)
    );

    srle_queue #(
        .WIDTH (BUN_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (bun_in),
        .i_pop   (pop),
        .o_data  (bun_out),
        .o_stat  (qstat)
    );

    srle_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_qstat        (qstat),
        .i_bundle       (bun_out),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_out_addr     (o_out_addr),
        .o_last_of_item (o_last_of_item)
    );

endmodule

`default_nettype wire

[sv/srle_front.sv]
// ----------------------------------------------------------------------------
// srle_front: pixel intake and run tracking
// Accepts one pixel per cycle while the queue has room, updates the open run
// and write address, and makes a bundle of up to four addressed byte writes.
// ----------------------------------------------------------------------------
`default_nettype none

module srle_front #(
    parameter int MAX_RUN   = srle_pkg::DEF_MAX_RUN,
    parameter int ADDR_BITS = srle_pkg::DEF_ADDR_BITS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [7:0]              i_pixel,
    input  wire logic                    i_row_end,
    input  wire logic                    i_image_start,
    input  wire srle_pkg::t_qstat        i_qstat,
    output logic                         o_push,
    output logic [srle_pkg::MAX_WRITES*(srle_pkg::BYTE_W+ADDR_BITS)
                  +srle_pkg::WIDX_W-1:0] o_bundle
);
    import srle_pkg::*;

    localparam int WRITE_W = BYTE_W + ADDR_BITS;
    localparam int BUN_W   = MAX_WRITES * WRITE_W + WIDX_W;

    t_run_kind              r_kind, n_kind;
    logic [RUN_LEN_W-1:0]   r_len, n_len;
    logic [ADDR_BITS-1:0]   r_slot, n_slot;
    logic [ADDR_BITS-1:0]   r_wa, n_wa;

    t_run_kind              kind_in;
    logic [CNT_W-1:0]       wr_cnt;
    logic [BYTE_W-1:0]      wr_byte [MAX_WRITES];
    logic [ADDR_BITS-1:0]   wr_addr [MAX_WRITES];
    logic                   accept;

    assign o_ready = !i_qstat.full;
    assign accept  = i_valid && o_ready;
    assign kind_in = (i_pixel != '0) ? RUN_OPAQUE : RUN_TRANS;

    // The pixel is walked through the same steps as the encoding rules:
    // close a mismatched or full run, open a run, store the pixel, end the row.
    always_comb begin
        n_kind = r_kind;
        n_len  = r_len;
        n_slot = r_slot;
        n_wa   = r_wa;
        wr_cnt = '0;
        for (int k = 0; k < MAX_WRITES; k++) begin
            wr_byte[k] = '0;
            wr_addr[k] = '0;
        end

        if (i_image_start) begin
            n_kind = RUN_NONE;
            n_len  = '0;
            n_wa   = '0;
        end

        if (n_kind != RUN_NONE &&
            (n_kind != kind_in || n_len >= RUN_LEN_W'(MAX_RUN))) begin
            if (n_kind == RUN_OPAQUE) begin
                wr_byte[wr_cnt[WIDX_W-1:0]] = {1'b0, n_len};
                wr_addr[wr_cnt[WIDX_W-1:0]] = n_slot;
            end else begin
                wr_byte[wr_cnt[WIDX_W-1:0]] = ROW_MARK | {1'b0, n_len};
                wr_addr[wr_cnt[WIDX_W-1:0]] = n_wa;
                n_wa = n_wa + ADDR_BITS'(1);
            end
            wr_cnt = wr_cnt + CNT_W'(1);
            n_kind = RUN_NONE;
            n_len  = '0;
        end

        if (n_kind == RUN_NONE) begin
            n_kind = kind_in;
            n_len  = '0;
            if (kind_in == RUN_OPAQUE) begin
                n_slot = n_wa;
                n_wa   = n_wa + ADDR_BITS'(1);
            end
        end

        if (kind_in == RUN_OPAQUE) begin
            wr_byte[wr_cnt[WIDX_W-1:0]] = i_pixel;
            wr_addr[wr_cnt[WIDX_W-1:0]] = n_wa;
            wr_cnt = wr_cnt + CNT_W'(1);
            n_wa   = n_wa + ADDR_BITS'(1);
        end
        n_len = n_len + RUN_LEN_W'(1);

        // A transparent run that reaches the row end is dropped.
        if (i_row_end) begin
            if (n_kind == RUN_OPAQUE) begin
                wr_byte[wr_cnt[WIDX_W-1:0]] = {1'b0, n_len};
                wr_addr[wr_cnt[WIDX_W-1:0]] = n_slot;
                wr_cnt = wr_cnt + CNT_W'(1);
            end
            wr_byte[wr_cnt[WIDX_W-1:0]] = ROW_MARK;
            wr_addr[wr_cnt[WIDX_W-1:0]] = n_wa;
            wr_cnt = wr_cnt + CNT_W'(1);
            n_wa   = n_wa + ADDR_BITS'(1);
            n_kind = RUN_NONE;
            n_len  = '0;
        end
    end

    always_comb begin
        o_bundle = '0;
        for (int k = 0; k < MAX_WRITES; k++) begin
            o_bundle[k*WRITE_W +: BYTE_W]         = wr_byte[k];
            o_bundle[k*WRITE_W+BYTE_W +: ADDR_BITS] = wr_addr[k];
        end
        o_bundle[BUN_W-1 -: WIDX_W] = WIDX_W'(wr_cnt - CNT_W'(1));
    end

    // Pixels that cause no write never enter the queue.
    assign o_push = accept && (wr_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= RUN_NONE;
            r_len  <= '0;
            r_slot <= '0;
            r_wa   <= '0;
        end else if (accept) begin
            r_kind <= n_kind;
            r_len  <= n_len;
            r_slot <= n_slot;
            r_wa   <= n_wa;
        end
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= RUN_LEN_W'(MAX_RUN))
        else $error("open run longer than the maximum run");

    a_none_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kind == RUN_NONE |-> r_len == '0)
        else $error("closed run still holds a length");

    a_row_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_row_end |=> r_kind == RUN_NONE)
        else $error("run left open after a row end");

endmodule

`default_nettype wire

[sv/srle_queue.sv]
// ----------------------------------------------------------------------------
// srle_queue: short queue of write bundles
// Decouples pixel intake from the serial byte writer.
// ----------------------------------------------------------------------------
`default_nettype none

module srle_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = srle_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output srle_pkg::t_qstat      o_stat
);
    import srle_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_Q = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_Q-1:0] r_count, n_count;

    assign o_stat.full  = (r_count == CNT_Q'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_data       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_Q'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_Q'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("bundle pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("bundle popped from an empty queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + CNT_Q'(1))
        else $error("queue fill count out of step with pushes");

endmodule

`default_nettype wire

[sv/srle_back.sv]
// ----------------------------------------------------------------------------
// srle_back: serial byte writer
// Takes write bundles from the queue and issues their writes one per cycle
// while the receiver is ready, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srle_back #(
    parameter int ADDR_BITS = srle_pkg::DEF_ADDR_BITS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire srle_pkg::t_qstat        i_qstat,
    input  wire logic [srle_pkg::MAX_WRITES*(srle_pkg::BYTE_W+ADDR_BITS)
                       +srle_pkg::WIDX_W-1:0] i_bundle,
    output logic                         o_pop,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [7:0]                   o_out_byte,
    output logic [ADDR_BITS-1:0]         o_out_addr,
    output logic                         o_last_of_item
);
    import srle_pkg::*;

    localparam int WRITE_W = BYTE_W + ADDR_BITS;
    localparam int BUN_W   = MAX_WRITES * WRITE_W + WIDX_W;

    logic [BUN_W-1:0]     r_bun;
    logic                 r_have;
    logic [WIDX_W-1:0]    r_idx;
    logic                 r_out_valid;
    logic [BYTE_W-1:0]    r_out_byte;
    logic [ADDR_BITS-1:0] r_out_addr;
    logic                 r_out_last;

    logic                 out_free;
    logic                 emit;
    logic                 last_w;

    assign out_free = !r_out_valid || i_ready;
    assign emit     = r_have && out_free;
    assign last_w   = (r_idx == r_bun[BUN_W-1 -: WIDX_W]);
    // The next bundle is loaded in the cycle the current one issues its last write.
    assign o_pop    = !i_qstat.empty && (!r_have || (emit && last_w));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_have <= 1'b1;
                r_idx  <= '0;
            end else if (emit) begin
                if (last_w) begin
                    r_have <= 1'b0;
                end else begin
                    r_idx <= r_idx + WIDX_W'(1);
                end
            end
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bun <= i_bundle;
        end
        if (emit) begin
            r_out_byte <= r_bun[r_idx*WRITE_W +: BYTE_W];
            r_out_addr <= r_bun[r_idx*WRITE_W+BYTE_W +: ADDR_BITS];
            r_out_last <= last_w;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_out_addr     = r_out_addr;
    assign o_last_of_item = r_out_last;

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> r_idx <= r_bun[BUN_W-1 -: WIDX_W])
        else $error("write index beyond the bundle size");

    a_pop_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && r_have |-> emit && last_w)
        else $error("bundle replaced before all its writes were issued");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> o_valid)
        else $error("issued write not presented on the output");

endmodule

`default_nettype wire

[tb/sprite_row_rle_encoder_top_test.sv]
// ----------------------------------------------------------------------------
// sprite_row_rle_encoder_top_test: self-checking bench for the run encoder
// Streams pixel words with row-end and image-start marks into the encoder and
// checks every byte write against a cycle-free model of the run encoding.
// Both channels idle at random. The output side also holds off for a long
// stretch so that the write queue fills.
// ----------------------------------------------------------------------------
module sprite_row_rle_encoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import srle_pkg::*;

    localparam int ADDR_W     = DEF_ADDR_BITS;
    localparam int RUN_LIMIT  = DEF_MAX_RUN;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_LEN   = 80;
    localparam int RAND_ITEMS = 260;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [ADDR_W-1:0] addr;
        logic              is_last;
    } t_write;

    // Predicts the byte writes of each pixel and checks them in order.
    class rle_scoreboard;
        t_run_kind              run_kind;
        logic [RUN_LEN_W-1:0]   run_len;
        logic [ADDR_W-1:0]      hdr_slot;
        logic [ADDR_W-1:0]      next_addr;
        t_write                 writes_due[$];
        int errors, pixels, rows, starts, full_runs, writes_seen;

        function new();
            run_kind = RUN_NONE;
            run_len = '0;
            hdr_slot = '0;
            next_addr = '0;
            errors = 0;
            pixels = 0;
            rows = 0;
            starts = 0;
            full_runs = 0;
            writes_seen = 0;
        endfunction

        function void emit_at(logic [BYTE_W-1:0] data, logic [ADDR_W-1:0] addr);
            t_write w;
            w.data = data;
            w.addr = addr;
            w.is_last = 1'b0;
            writes_due.push_back(w);
        endfunction

        function void emit_next(logic [BYTE_W-1:0] data);
            emit_at(data, next_addr);
            next_addr = next_addr + 1'b1;
        endfunction

        // A transparent run that touches the row end leaves no header.
        function void close_run(bit at_row_end);
            if (run_kind == RUN_OPAQUE) begin
                emit_at({1'b0, run_len}, hdr_slot);
            end else if (run_kind == RUN_TRANS && !at_row_end) begin
                emit_next(ROW_MARK | {1'b0, run_len});
            end
            run_kind = RUN_NONE;
            run_len = '0;
        endfunction

        function void note_pixel(logic [7:0] pix, logic row_end, logic img_start);
            t_run_kind pix_kind;
            int first;
            pix_kind = (pix != 8'd0) ? RUN_OPAQUE : RUN_TRANS;
            first = writes_due.size();
            pixels++;
            if (img_start) begin
                starts++;
                run_kind = RUN_NONE;
                run_len = '0;
                next_addr = '0;
            end
            if (run_kind != RUN_NONE && (run_kind != pix_kind || run_len >= RUN_LIMIT)) begin
                if (run_kind == pix_kind)
                    full_runs++;
                close_run(1'b0);
            end
            if (run_kind == RUN_NONE) begin
                run_kind = pix_kind;
                run_len = '0;
                if (pix_kind == RUN_OPAQUE) begin
                    hdr_slot = next_addr;
                    next_addr = next_addr + 1'b1;
                end
            end
            if (pix_kind == RUN_OPAQUE)
                emit_next(pix);
            run_len = run_len + 1'b1;
            if (row_end) begin
                rows++;
                close_run(1'b1);
                emit_next(ROW_MARK);
            end
            if (writes_due.size() > first)
                writes_due[writes_due.size() - 1].is_last = 1'b1;
        endfunction

        function void check_write(logic [BYTE_W-1:0] data, logic [ADDR_W-1:0] addr,
                                  logic is_last);
            t_write due;
            writes_seen++;
            if (writes_due.size() == 0) begin
                errors++;
                $display("%0t: write with nothing due: byte %02h addr %06h last %0b",
                         $time, data, addr, is_last);
                return;
            end
            due = writes_due.pop_front();
            if (due.data !== data) begin
                errors++;
                $display("%0t: byte mismatch: expected %02h, got %02h",
                         $time, due.data, data);
            end
            if (due.addr !== addr) begin
                errors++;
                $display("%0t: address mismatch: expected %06h, got %06h",
                         $time, due.addr, addr);
            end
            if (due.is_last !== is_last) begin
                errors++;
                $display("%0t: last-of-item mismatch: expected %0b, got %0b",
                         $time, due.is_last, is_last);
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [7:0]          i_pixel;
    logic                i_row_end;
    logic                i_image_start;
    logic                o_valid;
    logic                i_ready;
    logic [7:0]          o_out_byte;
    logic [ADDR_W-1:0]   o_out_addr;
    logic                o_last_of_item;

    rle_scoreboard sb = new();
    bit no_idle;
    bit hold_req;

    sprite_row_rle_encoder_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_pixel        (i_pixel),
        .i_row_end      (i_row_end),
        .i_image_start  (i_image_start),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_out_addr     (o_out_addr),
        .o_last_of_item (o_last_of_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly back to back, often a short gap, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Entered and left at a falling edge; the edge of entry carries no assignment yet.
    task automatic send_pixel(logic [7:0] pix, logic row_end, logic img_start);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= pix;
        i_row_end <= row_end;
        i_image_start <= img_start;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        sb.note_pixel(pix, row_end, img_start);
        @(negedge i_clk);
    endtask

    task automatic wait_all_written();
        i_valid <= 1'b0;
        while (sb.writes_due.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // One row as a chain of runs; a long first run crosses the run length limit.
    task automatic send_row(t_run_kind long_kind);
        int n_runs;
        int len;
        t_run_kind kind;
        logic start_flag;
        logic mark_start;
        logic long_run;
        logic [7:0] pix;
        n_runs = (long_kind == RUN_NONE) ? $urandom_range(1, 4) : $urandom_range(2, 3);
        start_flag = ($urandom_range(0, 5) == 0);
        for (int r = 0; r < n_runs; r++) begin
            long_run = (r == 0 && long_kind != RUN_NONE);
            if (long_run) begin
                kind = long_kind;
                len = $urandom_range(RUN_LIMIT + 1, RUN_LIMIT + 4);
            end else begin
                kind = ($urandom_range(0, 9) < 6) ? RUN_OPAQUE : RUN_TRANS;
                len = $urandom_range(1, 4);
            end
            for (int i = 0; i < len; i++) begin
                pix = (kind == RUN_OPAQUE) ? 8'($urandom_range(1, 255)) : 8'd0;
                // A long run is kept whole so that it really reaches the limit.
                mark_start = start_flag || (!long_run && ($urandom_range(0, 39) == 0));
                send_pixel(pix, (r == n_runs - 1) && (i == len - 1), mark_start);
                start_flag = 1'b0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_write(o_out_byte, o_out_addr, o_last_of_item);
    end

    initial begin : receiver
        int stall;
        int hold_left;
        stall = 0;
        hold_left = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_LEN;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle = 0;
            else
                idle++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        t_run_kind long_kind;
        int row_no;
        int stop_at;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_pixel = 8'd0;
        i_row_end = 1'b0;
        i_image_start = 1'b0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Opaque run closed by a transparent one, then a row end that closes
        // a transparent run and an opaque run in the same word: four writes.
        send_pixel(8'h05, 1'b0, 1'b1);
        send_pixel(8'hff, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'h01, 1'b1, 1'b0);
        // Trailing transparent run is dropped.
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b1, 1'b0);
        send_pixel(8'h80, 1'b1, 1'b0);
        send_pixel(8'h00, 1'b1, 1'b0);
        // Image start abandons an open opaque run, then an open transparent run.
        send_pixel(8'h7f, 1'b0, 1'b0);
        send_pixel(8'haa, 1'b0, 1'b1);
        send_pixel(8'h55, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b1);
        // Image start and row end on the same pixel.
        send_pixel(8'h00, 1'b1, 1'b1);
        send_pixel(8'h33, 1'b1, 1'b1);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'hfe, 1'b0, 1'b0);
        send_pixel(8'h01, 1'b1, 1'b0);
        wait_all_written();

        stop_at = sb.pixels + RAND_ITEMS;
        row_no = 0;
        while (sb.pixels < stop_at) begin
            long_kind = (row_no == 1) ? RUN_OPAQUE : (row_no == 3) ? RUN_TRANS : RUN_NONE;
            // A burst with no gaps while the output side holds off.
            if (row_no == 0) begin
                no_idle = 1'b1;
                hold_req = 1'b1;
            end
            if (row_no == 2) begin
                no_idle = 1'b0;
                wait_all_written();
            end
            send_row(long_kind);
            row_no++;
        end
        wait_all_written();
        repeat (10) @(negedge i_clk);

        $display("Encoded %0d pixels in %0d rows with %0d image starts;", sb.pixels,
                 sb.rows, sb.starts);
        $display("%0d runs split at the length limit, %0d byte writes checked.",
                 sb.full_runs, sb.writes_seen);
        if (sb.errors == 0 && sb.writes_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
